// ----- design/critical_edge_bridge_check_macros.svh -----
// Assertion macros shared by the critical edge bridge check RTL.
// Included by modules that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef CRITICAL_EDGE_BRIDGE_CHECK_MACROS_SVH
`define CRITICAL_EDGE_BRIDGE_CHECK_MACROS_SVH

// Invariant checked at every clock edge outside reset
`define CEBC_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Antecedent this cycle implies consequent next cycle
`define CEBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cebc_pkg.sv -----
// Shared constants, command codes and inter-module structs for the bridge check.
// No dependencies; used by all RTL modules through scoped names.
`default_nettype none

package cebc_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int MAX_EDGES    = 64;
    localparam int VERT_W       = 5;   // vertex number
    localparam int CNT_W        = 6;   // vertex count, times, stack depth
    localparam int EIDX_W       = 6;   // edge list address
    localparam int ECNT_W       = 7;   // edge count, may equal MAX_EDGES

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    // Requests from the sequencer to the search engine
    typedef struct packed {
        logic              start;
        logic [VERT_W-1:0] rm_a;
        logic [VERT_W-1:0] rm_b;
        logic              add;
        logic [VERT_W-1:0] add_a;
        logic [VERT_W-1:0] add_b;
        logic              clear;
    } t_srch_req;

    // Search engine status
    typedef struct packed {
        logic busy;
        logic done;
        logic bridge;
    } t_srch_rsp;

endpackage

`default_nettype wire

// ----- design/cebc_edge_mem.sv -----
// Edge list storage: one write port, one registered read port.
// Depends on cebc_pkg for widths and depth.
`default_nettype none

module cebc_edge_mem (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [cebc_pkg::EIDX_W-1:0] i_wr_addr,
    input  wire logic [cebc_pkg::VERT_W-1:0] i_wr_a,
    input  wire logic [cebc_pkg::VERT_W-1:0] i_wr_b,
    input  wire logic [cebc_pkg::EIDX_W-1:0] i_rd_addr,
    output logic      [cebc_pkg::VERT_W-1:0] o_rd_a,
    output logic      [cebc_pkg::VERT_W-1:0] o_rd_b
);

    logic [2*cebc_pkg::VERT_W-1:0] r_mem [cebc_pkg::MAX_EDGES];
    logic [2*cebc_pkg::VERT_W-1:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_a, i_wr_b};
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_a = r_rd[2*cebc_pkg::VERT_W-1:cebc_pkg::VERT_W];
    assign o_rd_b = r_rd[cebc_pkg::VERT_W-1:0];

endmodule

`default_nettype wire

// ----- design/cebc_search.sv -----
// Adjacency matrix and iterative bridge search engine (DFS with explicit stack).
// One neighbor compare per cycle; depends on cebc_pkg and the assertion macros.
`default_nettype none
`include "critical_edge_bridge_check_macros.svh"

module cebc_search (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire cebc_pkg::t_srch_req        i_req,
    input  wire logic [cebc_pkg::CNT_W-1:0] i_n,
    output cebc_pkg::t_srch_rsp             o_rsp
);

    localparam int NV = cebc_pkg::MAX_VERTICES;
    localparam int VW = cebc_pkg::VERT_W;
    localparam int CW = cebc_pkg::CNT_W;

    typedef enum logic [1:0] {S_IDLE, S_ROOT, S_SCAN, S_DONE} t_state;

    // adjacency, per-vertex data and suspended frames
    logic [NV-1:0] r_adj     [NV];
    logic [NV-1:0] r_visited;
    logic [CW-1:0] r_disc    [NV];
    logic [VW-1:0] r_stk_vtx [NV];
    logic [CW-1:0] r_stk_next[NV];
    logic [CW-1:0] r_stk_low [NV];
    logic [CW-1:0] r_stk_disc[NV];
    logic [VW-1:0] r_stk_par [NV];

    // control and top-of-stack frame
    t_state        r_state, n_state;
    logic [CW-1:0] r_sp, n_sp;
    logic [CW-1:0] r_root, n_root;
    logic [CW-1:0] r_vcnt, n_vcnt;
    logic          r_bridge, n_bridge;
    logic [VW-1:0] r_rm_a, n_rm_a, r_rm_b, n_rm_b;
    logic [VW-1:0] r_tu, n_tu, r_tpar, n_tpar;
    logic [CW-1:0] r_tnext, n_tnext, r_tlow, n_tlow, r_tdisc, n_tdisc;

    // store write controls
    logic          vis_clr, vis_set, disc_we, stk_we;
    logic [VW-1:0] vis_addr;
    logic [CW-1:0] disc_val;

    // scan unit signals
    logic [VW-1:0] w5, pidx;
    logic          w_end, is_rm, nb;
    logic [CW-1:0] vnext;

    always_comb begin
        w5    = r_tnext[VW-1:0];
        w_end = (r_tnext >= i_n);
        pidx  = VW'(r_sp - CW'(2));
        vnext = r_vcnt + CW'(1);
        is_rm = ((r_tu == r_rm_a) && (w5 == r_rm_b)) || ((r_tu == r_rm_b) && (w5 == r_rm_a));
        nb    = r_adj[r_tu][w5] && (w5 != r_tu) && !((r_sp >= CW'(2)) && (w5 == r_tpar))
                && !is_rm;
    end

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_sp     = r_sp;
        n_root   = r_root;
        n_vcnt   = r_vcnt;
        n_bridge = r_bridge;
        n_rm_a   = r_rm_a;
        n_rm_b   = r_rm_b;
        n_tu     = r_tu;
        n_tpar   = r_tpar;
        n_tnext  = r_tnext;
        n_tlow   = r_tlow;
        n_tdisc  = r_tdisc;
        vis_clr  = 1'b0;
        vis_set  = 1'b0;
        vis_addr = r_tu;
        disc_we  = 1'b0;
        disc_val = vnext;
        stk_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_rm_a   = i_req.rm_a;
                    n_rm_b   = i_req.rm_b;
                    n_root   = '0;
                    n_vcnt   = '0;
                    n_bridge = 1'b0;
                    vis_clr  = 1'b1;
                    n_state  = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_root >= i_n) begin
                    n_state = S_DONE;
                end else if (r_visited[r_root[VW-1:0]]) begin
                    n_root = r_root + CW'(1);
                end else begin
                    vis_set  = 1'b1;
                    vis_addr = r_root[VW-1:0];
                    disc_we  = 1'b1;
                    n_vcnt   = vnext;
                    n_tu     = r_root[VW-1:0];
                    n_tnext  = '0;
                    n_tlow   = vnext;
                    n_tdisc  = vnext;
                    n_sp     = CW'(1);
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_end) begin
                    // frame finished: pop and fold low-link into parent
                    n_sp = r_sp - CW'(1);
                    if (r_sp == CW'(1)) begin
                        n_root  = r_root + CW'(1);
                        n_state = S_ROOT;
                    end else begin
                        n_tu    = r_stk_vtx[pidx];
                        n_tnext = r_stk_next[pidx];
                        n_tdisc = r_stk_disc[pidx];
                        n_tpar  = r_stk_par[pidx];
                        n_tlow  = (r_tlow < r_stk_low[pidx]) ? r_tlow : r_stk_low[pidx];
                        if (r_tlow > r_stk_disc[pidx]) begin
                            n_bridge = 1'b1;
                        end
                    end
                end else if (!nb) begin
                    n_tnext = r_tnext + CW'(1);
                end else begin
                    n_tnext = r_tnext + CW'(1);
                    if (r_visited[w5]) begin
                        if (r_disc[w5] < r_tlow) begin
                            n_tlow = r_disc[w5];
                        end
                    end else if (r_sp < CW'(NV)) begin
                        // descend: suspend current frame
                        stk_we   = 1'b1;
                        vis_set  = 1'b1;
                        vis_addr = w5;
                        disc_we  = 1'b1;
                        n_vcnt   = vnext;
                        n_tpar   = r_tu;
                        n_tu     = w5;
                        n_tnext  = '0;
                        n_tlow   = vnext;
                        n_tdisc  = vnext;
                        n_sp     = r_sp + CW'(1);
                    end
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sp     <= '0;
            r_root   <= '0;
            r_vcnt   <= '0;
            r_bridge <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_root   <= n_root;
            r_vcnt   <= n_vcnt;
            r_bridge <= n_bridge;
        end
    end

    // frame payload registers
    always_ff @(posedge i_clk) begin
        r_rm_a  <= n_rm_a;
        r_rm_b  <= n_rm_b;
        r_tu    <= n_tu;
        r_tpar  <= n_tpar;
        r_tnext <= n_tnext;
        r_tlow  <= n_tlow;
        r_tdisc <= n_tdisc;
    end

    // adjacency matrix: symmetric set on add, full clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            for (int i = 0; i < NV; i++) begin
                r_adj[i] <= '0;
            end
        end else if (i_req.add) begin
            r_adj[i_req.add_a][i_req.add_b] <= 1'b1;
            r_adj[i_req.add_b][i_req.add_a] <= 1'b1;
        end
    end

    // visited flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || vis_clr) begin
            r_visited <= '0;
        end else if (vis_set) begin
            r_visited[vis_addr] <= 1'b1;
        end
    end

    // discovery times and suspended frames
    always_ff @(posedge i_clk) begin
        if (disc_we) begin
            r_disc[vis_addr] <= disc_val;
        end
        if (stk_we) begin
            r_stk_vtx[VW'(r_sp - CW'(1))]  <= r_tu;
            r_stk_next[VW'(r_sp - CW'(1))] <= r_tnext + CW'(1);
            r_stk_low[VW'(r_sp - CW'(1))]  <= r_tlow;
            r_stk_disc[VW'(r_sp - CW'(1))] <= r_tdisc;
            r_stk_par[VW'(r_sp - CW'(1))]  <= r_tpar;
        end
    end

    assign o_rsp.busy   = (r_state != S_IDLE);
    assign o_rsp.done   = (r_state == S_DONE);
    assign o_rsp.bridge = r_bridge;

    `CEBC_ASSERT(a_sp_range, r_sp <= CW'(NV), "stack depth beyond vertex limit")
    `CEBC_ASSERT(a_scan_frame, (r_state != S_SCAN) || (r_sp != '0), "scan without a frame")
    `CEBC_ASSERT_NEXT(a_done_idle, r_state == S_DONE, r_state == S_IDLE, "done not followed by idle")

endmodule

`default_nettype wire

// ----- design/critical_edge_bridge_check.sv -----
// A run takes each stored edge in turn: its endpoints are read from the edge list, the
// search starts with that edge removed, and the sequencer waits for done. The search
// tries each root, scans every neighbor slot of each visited vertex, pops each finished
// frame and ends in a done state. Each qualifying edge after the first passes through
// an emit state, and output stalls hold the run. One item at a time.
// Synchronous active-low reset clears the matrix, edge count, drop flag, vertex_count=32.
`default_nettype none
`include "critical_edge_bridge_check_macros.svh"

module critical_edge_bridge_check (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [5:0] i_cfg_vertex_count,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_cmd,
    input  wire logic [4:0] i_end_a,
    input  wire logic [4:0] i_end_b,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [4:0]      o_crit_a,
    output logic [4:0]      o_crit_b,
    output logic [5:0]      o_crit_index,
    output logic            o_none_found,
    output logic            o_edges_dropped,
    output logic            o_last
);

    localparam int VW = cebc_pkg::VERT_W;
    localparam int CW = cebc_pkg::CNT_W;
    localparam int EW = cebc_pkg::EIDX_W;
    localparam int KW = cebc_pkg::ECNT_W;

    typedef enum logic [2:0] {T_IDLE, T_NEXT, T_LOAD, T_WAIT, T_EMIT, T_FINAL} t_state;

    t_state        r_state;
    logic [CW-1:0] r_vc;
    logic [KW-1:0] r_edge_count;
    logic          r_drop;
    logic [KW-1:0] r_idx;
    logic [VW-1:0] r_cur_a, r_cur_b;
    logic          r_pend;
    logic [VW-1:0] r_pend_a, r_pend_b;
    logic [EW-1:0] r_pend_idx;
    logic          r_ovalid, r_onone, r_odrop, r_olast;
    logic [VW-1:0] r_oa, r_ob;
    logic [EW-1:0] r_oidx;

    logic [CW-1:0]       eff_n;
    logic                in_acc, add_ok, slot_free, out_load, none_ok;
    logic [VW-1:0]       rd_a, rd_b;
    cebc_pkg::t_srch_req srch_req;
    cebc_pkg::t_srch_rsp srch_rsp;

    // effective vertex count and handshakes
    assign eff_n       = (r_vc > CW'(cebc_pkg::MAX_VERTICES)) ?
                         CW'(cebc_pkg::MAX_VERTICES) : r_vc;
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == T_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign slot_free   = !r_ovalid || i_out_ready;
    assign out_load    = slot_free && ((r_state == T_EMIT) || (r_state == T_FINAL));
    assign add_ok      = (CW'(i_end_a) < eff_n) && (CW'(i_end_b) < eff_n)
                         && (r_edge_count < KW'(cebc_pkg::MAX_EDGES));

    // requests to the search engine
    always_comb begin
        srch_req       = '0;
        srch_req.start = (r_state == T_LOAD);
        srch_req.rm_a  = rd_a;
        srch_req.rm_b  = rd_b;
        srch_req.add_a = i_end_a;
        srch_req.add_b = i_end_b;
        if (in_acc) begin
            case (cebc_pkg::t_cmd'(i_cmd))
                cebc_pkg::CMD_ADD:   srch_req.add   = add_ok;
                cebc_pkg::CMD_CLEAR: srch_req.clear = 1'b1;
                default:             srch_req.add   = 1'b0;
            endcase
        end
    end

    cebc_edge_mem u_edge_mem (
        .i_clk     (i_clk),
        .i_wr_en   (srch_req.add),
        .i_wr_addr (r_edge_count[EW-1:0]),
        .i_wr_a    (i_end_a),
        .i_wr_b    (i_end_b),
        .i_rd_addr (r_idx[EW-1:0]),
        .o_rd_a    (rd_a),
        .o_rd_b    (rd_b)
    );

    cebc_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (srch_req),
        .i_n     (eff_n),
        .o_rsp   (srch_rsp)
    );

    // run sequencer, graph bookkeeping and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_vc         <= CW'(cebc_pkg::MAX_VERTICES);
            r_edge_count <= '0;
            r_drop       <= 1'b0;
            r_pend       <= 1'b0;
            r_ovalid     <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_vc <= i_cfg_vertex_count;
            end
            if (r_ovalid && i_out_ready && !out_load) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (in_acc) begin
                        case (cebc_pkg::t_cmd'(i_cmd))
                            cebc_pkg::CMD_ADD: begin
                                if (add_ok) begin
                                    r_edge_count <= r_edge_count + KW'(1);
                                end else begin
                                    r_drop <= 1'b1;
                                end
                            end
                            cebc_pkg::CMD_RUN: begin
                                r_idx   <= '0;
                                r_pend  <= 1'b0;
                                r_state <= T_NEXT;
                            end
                            cebc_pkg::CMD_CLEAR: begin
                                r_edge_count <= '0;
                                r_drop       <= 1'b0;
                            end
                            default: begin
                                r_state <= T_IDLE;
                            end
                        endcase
                    end
                end
                T_NEXT: begin
                    // edge list read issued at r_idx
                    r_state <= (r_idx >= r_edge_count) ? T_FINAL : T_LOAD;
                end
                T_LOAD: begin
                    r_cur_a <= rd_a;
                    r_cur_b <= rd_b;
                    r_state <= T_WAIT;
                end
                T_WAIT: begin
                    if (srch_rsp.done) begin
                        if (!srch_rsp.bridge) begin
                            r_idx   <= r_idx + KW'(1);
                            r_state <= T_NEXT;
                        end else if (!r_pend) begin
                            r_pend     <= 1'b1;
                            r_pend_a   <= r_cur_a;
                            r_pend_b   <= r_cur_b;
                            r_pend_idx <= r_idx[EW-1:0];
                            r_idx      <= r_idx + KW'(1);
                            r_state    <= T_NEXT;
                        end else begin
                            r_state <= T_EMIT;
                        end
                    end
                end
                T_EMIT: begin
                    // older qualifying edge goes out, newest is held back
                    if (slot_free) begin
                        r_ovalid   <= 1'b1;
                        r_oa       <= r_pend_a;
                        r_ob       <= r_pend_b;
                        r_oidx     <= r_pend_idx;
                        r_onone    <= 1'b0;
                        r_odrop    <= r_drop;
                        r_olast    <= 1'b0;
                        r_pend_a   <= r_cur_a;
                        r_pend_b   <= r_cur_b;
                        r_pend_idx <= r_idx[EW-1:0];
                        r_idx      <= r_idx + KW'(1);
                        r_state    <= T_NEXT;
                    end
                end
                T_FINAL: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        r_oa     <= r_pend ? r_pend_a : '0;
                        r_ob     <= r_pend ? r_pend_b : '0;
                        r_oidx   <= r_pend ? r_pend_idx : '0;
                        r_onone  <= !r_pend;
                        r_odrop  <= r_drop;
                        r_olast  <= 1'b1;
                        r_pend   <= 1'b0;
                        r_state  <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_crit_a        = r_oa;
    assign o_crit_b        = r_ob;
    assign o_crit_index    = r_oidx;
    assign o_none_found    = r_onone;
    assign o_edges_dropped = r_odrop;
    assign o_last          = r_olast;

    // a none-found result is the last one and carries zero fields
    assign none_ok = !(r_ovalid && r_onone)
                     || (r_olast && (r_oidx == '0) && (r_oa == '0) && (r_ob == '0));

    `CEBC_ASSERT(a_cnt_max, r_edge_count <= KW'(cebc_pkg::MAX_EDGES), "edge count overflow")
    `CEBC_ASSERT(a_none_last, none_ok, "none-found result malformed")
    `CEBC_ASSERT_NEXT(a_start_busy, r_state == T_LOAD, srch_rsp.busy, "search did not start")

endmodule

`default_nettype wire

// ----- tb/tb_critical_edge_bridge_check.sv -----
// Testbench for critical_edge_bridge_check: directed and random edge loads and runs.
// Predicts every run result in its own bridge search; needs only cebc_pkg and the RTL.
`timescale 1ns / 100ps

module tb_critical_edge_bridge_check;

    // Expected result of a run
    typedef struct {
        logic [4:0] crit_a;
        logic [4:0] crit_b;
        logic [5:0] crit_index;
        logic       none_found;
        logic       edges_dropped;
        logic       last;
    } t_crit_result;

    localparam int IDLE_LIMIT = 300000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [5:0] i_cfg_vertex_count = 6'd32;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_cmd = cebc_pkg::CMD_ADD;
    logic [4:0] i_end_a = '0;
    logic [4:0] i_end_b = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [4:0] o_crit_a;
    logic [4:0] o_crit_b;
    logic [5:0] o_crit_index;
    logic       o_none_found;
    logic       o_edges_dropped;
    logic       o_last;

    critical_edge_bridge_check dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_vertex_count(i_cfg_vertex_count),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_end_a(i_end_a), .i_end_b(i_end_b),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_crit_a(o_crit_a), .o_crit_b(o_crit_b), .o_crit_index(o_crit_index),
        .o_none_found(o_none_found), .o_edges_dropped(o_edges_dropped),
        .o_last(o_last)
    );

    // Predictor state
    logic [31:0] graph_adj [32];
    logic [4:0]  list_a [64];
    logic [4:0]  list_b [64];
    logic [6:0]  list_len = '0;
    logic        dropped = 1'b0;
    logic [5:0]  vcount = 6'd32;

    t_crit_result crit_queue [$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int runs_sent = 0;
    int burst_left = 0;
    int hold_req = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Tarjan bridge search over vertices below n; 1 if any bridge exists
    function automatic logic find_bridge(int n);
        logic        seen [32];
        logic [5:0]  disc [32];
        logic [5:0]  lowl [32];
        logic [4:0]  stk_v [32];
        logic [5:0]  stk_n [32];
        logic [5:0]  clock_cnt;
        logic        found;
        int sp, u, w, par, p;
        logic hp;
        for (int k = 0; k < 32; k++) seen[k] = 1'b0;
        clock_cnt = '0;
        found = 1'b0;
        for (int root = 0; root < n; root++) begin
            if (seen[root]) continue;
            seen[root] = 1'b1;
            clock_cnt++;
            disc[root] = clock_cnt;
            lowl[root] = clock_cnt;
            stk_v[0] = root[4:0];
            stk_n[0] = '0;
            sp = 1;
            while (sp > 0) begin
                u = stk_v[sp-1];
                hp = (sp >= 2);
                par = hp ? stk_v[sp-2] : 0;
                w = stk_n[sp-1];
                while (w < n && (!graph_adj[u][w] || w == u || (hp && w == par))) w++;
                if (w < n) begin
                    stk_n[sp-1] = 6'(w + 1);
                    if (seen[w]) begin
                        if (disc[w] < lowl[u]) lowl[u] = disc[w];
                    end else if (sp < 32) begin
                        seen[w] = 1'b1;
                        clock_cnt++;
                        disc[w] = clock_cnt;
                        lowl[w] = clock_cnt;
                        stk_v[sp] = w[4:0];
                        stk_n[sp] = '0;
                        sp++;
                    end
                end else begin
                    sp--;
                    if (sp > 0) begin
                        p = stk_v[sp-1];
                        if (lowl[u] < lowl[p]) lowl[p] = lowl[u];
                        if (lowl[u] > disc[p]) found = 1'b1;
                    end
                end
            end
        end
        return found;
    endfunction

    // Apply one accepted transaction to the predictor, queueing run results
    task automatic predict_item(logic [1:0] cmd, logic [4:0] a, logic [4:0] b);
        int n, cnt;
        logic had_ab, had_ba;
        t_crit_result r;
        n = (vcount > 32) ? 32 : int'(vcount);
        cnt = 0;
        if (cmd == cebc_pkg::CMD_ADD) begin
            if (a >= n || b >= n || list_len >= 64) begin
                dropped = 1'b1;
            end else begin
                graph_adj[a][b] = 1'b1;
                graph_adj[b][a] = 1'b1;
                list_a[list_len] = a;
                list_b[list_len] = b;
                list_len++;
            end
        end else if (cmd == cebc_pkg::CMD_CLEAR) begin
            for (int k = 0; k < 32; k++) graph_adj[k] = '0;
            list_len = '0;
            dropped = 1'b0;
        end else if (cmd == cebc_pkg::CMD_RUN) begin
            for (int i = 0; i < list_len; i++) begin
                had_ab = graph_adj[list_a[i]][list_b[i]];
                had_ba = graph_adj[list_b[i]][list_a[i]];
                graph_adj[list_a[i]][list_b[i]] = 1'b0;
                graph_adj[list_b[i]][list_a[i]] = 1'b0;
                r.none_found = 1'b0;
                r.crit_a = list_a[i];
                r.crit_b = list_b[i];
                r.crit_index = 6'(i);
                r.edges_dropped = dropped;
                r.last = 1'b0;
                if (find_bridge(n)) begin
                    crit_queue = {crit_queue, r};
                    cnt++;
                end
                graph_adj[list_a[i]][list_b[i]] = had_ab;
                graph_adj[list_b[i]][list_a[i]] = had_ba;
            end
            if (cnt == 0) begin
                r = '{5'd0, 5'd0, 6'd0, 1'b1, dropped, 1'b0};
                crit_queue = {crit_queue, r};
            end
            crit_queue[crit_queue.size() - 1].last = 1'b1;
            runs_sent++;
        end
    endtask

    // Send one transaction; sender runs in bursts with random gaps
    task automatic send_item(logic [1:0] cmd, logic [4:0] a, logic [4:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_end_a <= a;
        i_end_b <= b;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predict_item(cmd, a, b);
        items_sent++;
    endtask

    // Drain pending results, then let trailing adds settle
    task automatic wait_idle();
        if (burst_left != 0 || i_in_valid) i_in_valid <= 1'b0;
        burst_left = 0;
        while (crit_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(logic [5:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_vertex_count <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        vcount = value;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);            // empty graph
        send_item(cebc_pkg::CMD_ADD, 5'd0, 5'd31);
        send_item(cebc_pkg::CMD_ADD, 5'd31, 5'd0);           // repeated edge
        send_item(cebc_pkg::CMD_ADD, 5'd5, 5'd5);            // self loop
        send_item(cebc_pkg::CMD_ADD, 5'd31, 5'd30);
        send_item(cebc_pkg::CMD_ADD, 5'd30, 5'd0);
        send_item(cebc_pkg::CMD_ADD, 5'd1, 5'd30);
        send_item(CMD_UNUSED, 5'd31, 5'd31);                 // unused command
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
        send_item(cebc_pkg::CMD_CLEAR, 5'd21, 5'd10);
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
    endtask

    task automatic test_vertex_extremes();
        write_vertex_count(6'd0);                            // every add dropped
        send_item(cebc_pkg::CMD_ADD, 5'd0, 5'd0);
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
        write_vertex_count(6'd63);                           // clamps to 32
        send_item(cebc_pkg::CMD_CLEAR, 5'd0, 5'd0);
        send_item(cebc_pkg::CMD_ADD, 5'd31, 5'd30);
        send_item(cebc_pkg::CMD_ADD, 5'd29, 5'd30);
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
        write_vertex_count(6'd1);
        send_item(cebc_pkg::CMD_CLEAR, 5'd0, 5'd0);
        send_item(cebc_pkg::CMD_ADD, 5'd0, 5'd0);
        send_item(cebc_pkg::CMD_ADD, 5'd1, 5'd0);            // out of range
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
    endtask

    task automatic test_list_full();
        write_vertex_count(6'd4);
        send_item(cebc_pkg::CMD_CLEAR, 5'd0, 5'd0);
        for (int k = 0; k < 66; k++)
            send_item(cebc_pkg::CMD_ADD, 5'($urandom_range(0, 3)), 5'($urandom_range(0, 3)));
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
    endtask

    task automatic test_shrunk_count();
        write_vertex_count(6'd32);
        send_item(cebc_pkg::CMD_CLEAR, 5'd0, 5'd0);
        for (int k = 0; k < 8; k++)
            send_item(cebc_pkg::CMD_ADD, 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)));
        send_item(cebc_pkg::CMD_ADD, 5'd2, 5'd3);
        send_item(cebc_pkg::CMD_ADD, 5'd3, 5'd4);
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
        write_vertex_count(6'd6);                            // walk ignores vertices above 5
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
    endtask

    task automatic test_random_graphs();
        int n, k;
        logic [4:0] a, b;
        while (items_sent < 420) begin
            case ($urandom_range(0, 9))
                0: n = 32;
                1: n = $urandom_range(9, 31);
                default: n = $urandom_range(2, 8);
            endcase
            write_vertex_count(6'(n));
            send_item(cebc_pkg::CMD_CLEAR, 5'($urandom), 5'($urandom));
            k = (n > 12) ? $urandom_range(1, 6) : $urandom_range(1, 12);
            for (int j = 0; j < k; j++) begin
                a = 5'($urandom_range(0, n - 1));
                b = 5'($urandom_range(0, n - 1));
                case ($urandom_range(0, 11))
                    0: send_item(cebc_pkg::CMD_ADD, 5'($urandom), 5'($urandom));
                    1: send_item(CMD_UNUSED, 5'($urandom), 5'($urandom));
                    2: if (j > 0) send_item(cebc_pkg::CMD_ADD, b, a);
                    default: send_item(cebc_pkg::CMD_ADD, a, b);
                endcase
            end
            send_item(cebc_pkg::CMD_RUN, 5'($urandom), 5'($urandom));
            if ($urandom_range(0, 5) == 0) send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
        end
    endtask

    // Long receiver hold while a path graph run and more items are offered
    task automatic test_backpressure();
        write_vertex_count(6'd8);
        send_item(cebc_pkg::CMD_CLEAR, 5'd0, 5'd0);
        for (int k = 0; k < 7; k++) send_item(cebc_pkg::CMD_ADD, 5'(k), 5'(k + 1));
        hold_req = 600;
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
        send_item(cebc_pkg::CMD_ADD, 5'd7, 5'd0);
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
        send_item(cebc_pkg::CMD_ADD, 5'd2, 5'd5);
        send_item(cebc_pkg::CMD_RUN, 5'd0, 5'd0);
    endtask

    // Receiver: random stall pattern, long holds on request
    initial begin
        int hold_left, mode;
        hold_left = 0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (mode == 0) begin
                i_out_ready <= 1'b1;
            end else if (mode == 1) begin
                i_out_ready <= ($urandom_range(0, 3) != 0);
            end else begin
                i_out_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Result checker
    initial begin
        t_crit_result e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                results_seen++;
                if (crit_queue.size() == 0) begin
                    $error("unexpected result transaction crit_a=%0d crit_b=%0d",
                           o_crit_a, o_crit_b);
                    errors++;
                end else begin
                    e = crit_queue.pop_front();
                    if (o_crit_a !== e.crit_a) begin
                        $error("crit_a expected %0d actual %0d", e.crit_a, o_crit_a);
                        errors++;
                    end
                    if (o_crit_b !== e.crit_b) begin
                        $error("crit_b expected %0d actual %0d", e.crit_b, o_crit_b);
                        errors++;
                    end
                    if (o_crit_index !== e.crit_index) begin
                        $error("crit_index expected %0d actual %0d",
                               e.crit_index, o_crit_index);
                        errors++;
                    end
                    if (o_none_found !== e.none_found) begin
                        $error("none_found expected %0d actual %0d",
                               e.none_found, o_none_found);
                        errors++;
                    end
                    if (o_edges_dropped !== e.edges_dropped) begin
                        $error("edges_dropped expected %0d actual %0d",
                               e.edges_dropped, o_edges_dropped);
                        errors++;
                    end
                    if (o_last !== e.last) begin
                        $error("last expected %0d actual %0d", e.last, o_last);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles without any accepted transaction
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet);
                $display("tb_critical_edge_bridge_check failed");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        for (int k = 0; k < 32; k++) graph_adj[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_vertex_extremes();
        test_list_full();
        test_shrunk_count();
        test_backpressure();
        test_random_graphs();
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (crit_queue.size() != 0) begin
            $error("%0d expected results never arrived", crit_queue.size());
            errors++;
        end
        $display("covered %0d transactions, %0d runs, %0d results checked",
                 items_sent, runs_sent, results_seen);
        $display("vertex counts 0..63, full edge list, drops, repeats, self loops, stalls");
        if (errors == 0)
            $display("tb_critical_edge_bridge_check passed");
        else
            $display("tb_critical_edge_bridge_check failed");
        $finish;
    end

endmodule
